### rtl/core/ir_edge_duration_capture_top_macros.svh
// Assertion helpers shared by the capture block.
// Every check samples on the rising edge of clk and is off while rst_n is low.
`ifndef IR_EDGE_DURATION_CAPTURE_TOP_MACROS_SVH
`define IR_EDGE_DURATION_CAPTURE_TOP_MACROS_SVH

// A condition that must hold on every clock edge.
`define IRDC_CHECK(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define IRDC_CHECK_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define IRDC_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/irdc_pkg.sv
`default_nettype none

package irdc_pkg;

    // Capture buffer geometry.
    localparam int MAX_DURATIONS = 256;
    localparam int ADDR_W        = $clog2(MAX_DURATIONS);
    localparam int COUNT_W       = $clog2(MAX_DURATIONS + 1);

    // Fixed field widths of the channels.
    localparam int ACTION_W       = 2;
    localparam int READ_INDEX_W   = 8;
    localparam int STORED_COUNT_W = 9;
    localparam int DURATION_W     = 16;
    localparam int CFG_DATA_W     = 16;

    // Width used to compare a read index against the fill count.
    localparam int IDX_CMP_W = (COUNT_W > READ_INDEX_W) ? COUNT_W : READ_INDEX_W;

    localparam logic [DURATION_W-1:0] DURATION_MAX  = 16'hFFFF;
    localparam logic [DURATION_W-1:0] IDLE_RESET_US = 16'd15000;

    // Result queue between the front and back parts.
    localparam int Q_DEPTH = 4;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK  = 2'd0,
        ACT_EDGE  = 2'd1,
        ACT_READ  = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    typedef enum logic [0:0] {
        REG_ENABLE     = 1'b0,
        REG_IDLE_LIMIT = 1'b1
    } cfg_index_t;

    // Classified item handed from the front part to the back part.
    typedef struct packed {
        logic                      frame_ready;
        logic                      frame_active;
        logic                      frame_done;
        logic [STORED_COUNT_W-1:0] stored_count;
        logic                      read_hit;
    } stage_t;

    // One finished result waiting in the queue.
    typedef struct packed {
        logic                      frame_ready;
        logic                      frame_active;
        logic                      frame_done;
        logic [STORED_COUNT_W-1:0] stored_count;
        logic [DURATION_W-1:0]     read_duration;
    } result_t;

    // Access to the duration buffer issued by the front part.
    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     waddr;
        logic [DURATION_W-1:0] wdata;
        logic                  re;
        logic [ADDR_W-1:0]     raddr;
    } ram_req_t;

endpackage

`default_nettype wire

### rtl/core/irdc_channels.sv
`default_nettype none

// Input item channel.
interface irdc_item_if;
    import irdc_pkg::*;

    logic                    valid;
    logic                    ready;
    action_t                 action;
    logic [READ_INDEX_W-1:0] read_index;

    modport source (output valid, output action, output read_index, input ready);
    modport sink   (input valid, input action, input read_index, output ready);
endinterface

// Result item channel.
interface irdc_result_if;
    import irdc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      frame_ready;
    logic                      frame_active;
    logic                      frame_done;
    logic [STORED_COUNT_W-1:0] stored_count;
    logic [DURATION_W-1:0]     read_duration;

    modport source (output valid, output frame_ready, output frame_active,
                    output frame_done, output stored_count, output read_duration,
                    input ready);
    modport sink   (input valid, input frame_ready, input frame_active,
                    input frame_done, input stored_count, input read_duration,
                    output ready);
endinterface

`default_nettype wire

### rtl/core/irdc_ram.sv
`default_nettype none

module irdc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/core/irdc_front.sv
`default_nettype none
`include "ir_edge_duration_capture_top_macros.svh"

module irdc_front (
    input  logic                             clk,
    input  logic                             rst_n,
    irdc_item_if.sink                        items,
    input  logic                             cfg_we,
    input  irdc_pkg::cfg_index_t             cfg_index,
    input  logic [irdc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             take_ok,
    output logic                             stage_valid,
    output irdc_pkg::stage_t                 stage,
    output irdc_pkg::ram_req_t               ram_req
);
    import irdc_pkg::*;

    logic                  enable_reg, enable_next;
    logic [DURATION_W-1:0] idle_limit_reg, idle_limit_next;
    logic [COUNT_W-1:0]    total_reg, total_next;
    logic [DURATION_W-1:0] since_reg, since_next;
    logic                  recv_reg, recv_next;
    logic                  hold_reg, hold_next;
    logic                  accept;
    logic                  done;
    logic                  read_hit;
    logic [DURATION_W-1:0] since_inc;

    // A transfer is taken whenever the back part has room for its result.
    assign accept      = items.valid && take_ok;
    assign items.ready = take_ok;

    // Microsecond counter saturates at the largest duration.
    assign since_inc = (since_reg == DURATION_MAX) ? since_reg : since_reg + 1'b1;

    // Configuration register writes.
    always_comb
    begin
        enable_next     = enable_reg;
        idle_limit_next = idle_limit_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_ENABLE:     enable_next     = cfg_data[0];
                REG_IDLE_LIMIT: idle_limit_next = cfg_data[DURATION_W-1:0];
                default:        ;
            endcase
        end
    end

    // Frame state update and buffer access for the accepted item.
    always_comb
    begin
        total_next    = total_reg;
        since_next    = since_reg;
        recv_next     = recv_reg;
        hold_next     = hold_reg;
        done          = 1'b0;
        read_hit      = 1'b0;
        ram_req.we    = 1'b0;
        ram_req.waddr = total_reg[ADDR_W-1:0];
        ram_req.wdata = since_reg;
        ram_req.re    = 1'b0;
        ram_req.raddr = ADDR_W'(items.read_index);
        if (accept)
        begin
            case (items.action)
                ACT_TICK:
                begin
                    if (recv_reg)
                    begin
                        since_next = since_inc;
                        if (!hold_reg && (total_reg != '0) && (since_inc > idle_limit_reg))
                        begin
                            recv_next = 1'b0;
                            hold_next = 1'b1;
                            done      = 1'b1;
                        end
                    end
                end
                ACT_EDGE:
                begin
                    if (enable_reg && !hold_reg)
                    begin
                        if (!recv_reg)
                        begin
                            // First edge opens a new frame.
                            recv_next  = 1'b1;
                            total_next = '0;
                        end
                        else if (total_reg < COUNT_W'(MAX_DURATIONS))
                        begin
                            ram_req.we = 1'b1;
                            total_next = total_reg + 1'b1;
                        end
                        since_next = '0;
                    end
                end
                ACT_READ:
                begin
                    ram_req.re = 1'b1;
                    read_hit   = IDX_CMP_W'(items.read_index) < IDX_CMP_W'(total_reg);
                end
                ACT_CLEAR:
                begin
                    total_next = '0;
                    recv_next  = 1'b0;
                    hold_next  = 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Classified item for the back part.
    always_comb
    begin
        stage_valid        = accept;
        stage.frame_ready  = hold_next;
        stage.frame_active = recv_next;
        stage.frame_done   = done;
        stage.stored_count = STORED_COUNT_W'(total_next);
        stage.read_hit     = read_hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b1;
            idle_limit_reg <= IDLE_RESET_US;
            total_reg      <= '0;
            since_reg      <= '0;
            recv_reg       <= 1'b0;
            hold_reg       <= 1'b0;
        end
        else
        begin
            enable_reg     <= enable_next;
            idle_limit_reg <= idle_limit_next;
            total_reg      <= total_next;
            since_reg      <= since_next;
            recv_reg       <= recv_next;
            hold_reg       <= hold_next;
        end
    end

    `IRDC_CHECK(hold_excludes_recv, !(hold_reg && recv_reg), "held frame still receiving")
    `IRDC_CHECK(total_in_range, total_reg <= COUNT_W'(MAX_DURATIONS), "fill count overflow")
    `IRDC_CHECK_NEXT(held_edge_ignored, accept && (items.action == ACT_EDGE) && hold_reg, $stable(total_reg) && $stable(since_reg), "edge changed a held frame")

endmodule

`default_nettype wire

### rtl/core/irdc_back.sv
`default_nettype none
`include "ir_edge_duration_capture_top_macros.svh"

module irdc_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            stage_valid,
    input  irdc_pkg::stage_t                stage,
    input  logic [irdc_pkg::DURATION_W-1:0] ram_rdata,
    output logic                            take_ok,
    irdc_result_if.source                   results
);
    import irdc_pkg::*;

    localparam int CRED_W = QCNT_W + 1;

    logic                  s1_valid_reg;
    stage_t                s1_reg;
    result_t               q_mem_reg [Q_DEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]     cnt_reg, cnt_next;
    logic                  push;
    logic                  pop;
    result_t               push_item;
    result_t               head;

    // Room is counted for the item still waiting on the buffer read.
    assign take_ok = ({1'b0, cnt_reg} + CRED_W'(s1_valid_reg)) < CRED_W'(Q_DEPTH);

    assign push = s1_valid_reg;
    assign pop  = results.valid && results.ready;

    // Join the classified item with the buffer read data.
    always_comb
    begin
        push_item.frame_ready   = s1_reg.frame_ready;
        push_item.frame_active  = s1_reg.frame_active;
        push_item.frame_done    = s1_reg.frame_done;
        push_item.stored_count  = s1_reg.stored_count;
        push_item.read_duration = s1_reg.read_hit ? ram_rdata : '0;
    end

    // Queue pointers and fill level.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= stage_valid;
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            cnt_reg      <= cnt_next;
        end
    end

    // Payload storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (stage_valid)
        begin
            s1_reg <= stage;
        end
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Head of the queue drives the result channel.
    assign head                  = q_mem_reg[rd_ptr_reg];
    assign results.valid         = cnt_reg != '0;
    assign results.frame_ready   = head.frame_ready;
    assign results.frame_active  = head.frame_active;
    assign results.frame_done    = head.frame_done;
    assign results.stored_count  = head.stored_count;
    assign results.read_duration = head.read_duration;

    `IRDC_CHECK(queue_level_bound, cnt_reg <= QCNT_W'(Q_DEPTH), "result queue overfilled")
    `IRDC_CHECK_IMP(push_has_room, s1_valid_reg, cnt_reg < QCNT_W'(Q_DEPTH), "push into full queue")

endmodule

`default_nettype wire

### rtl/core/ir_edge_duration_capture_top.sv
// Infrared edge duration capture. Each input transfer is a one-microsecond
// tick, a line edge, a read of a stored duration or a clear; each one yields
// exactly one result transfer that reflects the state after it. The block takes
// one item every clock cycle while input ready is high; a result passes
// through the registered read of the 256-entry duration buffer and then
// enters a four-entry result queue. The queue lets the input keep
// flowing while the consumer stalls, and input ready drops only once the
// queue and the read stage hold four results. The buffer is not cleared after
// reset; only entries below the current count are ever returned. Registers:
// index 0 enable (bit 0, reset 1), index 1 idle limit in microseconds (reset
// 15000); write them only while no items are in flight.
`default_nettype none

module ir_edge_duration_capture_top (
    input  logic                            clk,
    input  logic                            rst_n,
    irdc_item_if.sink                       items,
    irdc_result_if.source                   results,
    input  logic                            cfg_we,
    input  irdc_pkg::cfg_index_t            cfg_index,
    input  logic [irdc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import irdc_pkg::*;

    logic                  take_ok;
    logic                  stage_valid;
    stage_t                stage;
    ram_req_t              ram_req;
    logic [DURATION_W-1:0] ram_rdata;

    // Front part: accepts items, keeps the frame state, drives the buffer.
    irdc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .items       (items),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .take_ok     (take_ok),
        .stage_valid (stage_valid),
        .stage       (stage),
        .ram_req     (ram_req)
    );

    // Duration buffer.
    irdc_ram #(
        .WIDTH (DURATION_W),
        .DEPTH (MAX_DURATIONS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    // Back part: joins read data and queues results for the consumer.
    irdc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .stage       (stage),
        .ram_rdata   (ram_rdata),
        .take_ok     (take_ok),
        .results     (results)
    );

endmodule

`default_nettype wire

### verif/tb_ir_edge_duration_capture_top.sv
`default_nettype none

module tb_ir_edge_duration_capture_top;
    import irdc_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 3_000_000;
    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned PHASE_ITEMS  = 340;
    localparam int unsigned PHASE_COUNT  = 5;
    localparam int unsigned DRAIN_CYCLES = 8;

    // One row of the directed plan: either a register write or a run of
    // identical input transfers, optionally with a hand-written expectation.
    typedef struct packed {
        bit                      is_write;
        cfg_index_t              sel;
        logic [CFG_DATA_W-1:0]   value;
        action_t                 act;
        logic [READ_INDEX_W-1:0] idx;
        int unsigned             reps;
        bit                      typed;
        result_t                 want;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    irdc_item_if   item_ch ();
    irdc_result_if status_ch ();

    ir_edge_duration_capture_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (item_ch),
        .results   (status_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predicted capture state and register copies.
    logic [DURATION_W-1:0]     dur_mem [MAX_DURATIONS];
    logic [STORED_COUNT_W-1:0] dur_count  = '0;
    logic [DURATION_W-1:0]     quiet_us   = '0;
    bit                        in_frame   = 1'b0;
    bit                        frame_held = 1'b0;
    bit                        cap_enable = 1'b1;
    logic [DURATION_W-1:0]     idle_us    = IDLE_RESET_US;

    // Expected status of every accepted item, oldest first.
    result_t status_due [$];
    plan_row_t plan [$];

    int unsigned faults      = 0;
    int unsigned sent        = 0;
    int unsigned received    = 0;
    int unsigned frames_done = 0;
    int unsigned read_hits   = 0;
    int unsigned cycles      = 0;

    // Stall control flags for the stimulus and the result sink.
    bit          hold_req = 1'b0;
    bit          held     = 1'b0;
    bit          steady   = 1'b0;
    int unsigned gap_free = 0;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Applies one input item to the predicted state and returns its status.
    function automatic result_t next_capture_status(action_t act,
                                                    logic [READ_INDEX_W-1:0] idx);
        result_t               s;
        bit                    done;
        logic [DURATION_W-1:0] rd;
        done = 1'b0;
        rd   = '0;
        case (act)
            ACT_TICK:
            begin
                if (in_frame)
                begin
                    if (quiet_us != DURATION_MAX)
                        quiet_us = quiet_us + 1'b1;
                    if (!frame_held && dur_count != 0 && quiet_us > idle_us)
                    begin
                        in_frame   = 1'b0;
                        frame_held = 1'b1;
                        done       = 1'b1;
                        frames_done++;
                    end
                end
            end
            ACT_EDGE:
            begin
                if (cap_enable && !frame_held)
                begin
                    if (!in_frame)
                    begin
                        in_frame  = 1'b1;
                        dur_count = '0;
                    end
                    else if (dur_count < MAX_DURATIONS)
                    begin
                        dur_mem[dur_count[ADDR_W-1:0]] = quiet_us;
                        dur_count = dur_count + 1'b1;
                    end
                    quiet_us = '0;
                end
            end
            ACT_READ:
            begin
                if (idx < dur_count)
                begin
                    rd = dur_mem[idx];
                    read_hits++;
                end
            end
            default:
            begin
                dur_count  = '0;
                in_frame   = 1'b0;
                frame_held = 1'b0;
            end
        endcase
        s.frame_ready   = frame_held;
        s.frame_active  = in_frame;
        s.frame_done    = done;
        s.stored_count  = dur_count;
        s.read_duration = rd;
        return s;
    endfunction

    function automatic result_t status(bit rdy, bit active, bit done, int cnt, int dur);
        result_t s;
        s.frame_ready   = rdy;
        s.frame_active  = active;
        s.frame_done    = done;
        s.stored_count  = STORED_COUNT_W'(cnt);
        s.read_duration = DURATION_W'(dur);
        return s;
    endfunction

    function automatic void plan_item(action_t act, logic [READ_INDEX_W-1:0] idx,
                                      int unsigned reps);
        plan_row_t r;
        r       = '0;
        r.act   = act;
        r.idx   = idx;
        r.reps  = reps;
        plan.push_back(r);
    endfunction

    function automatic void plan_typed(action_t act, logic [READ_INDEX_W-1:0] idx,
                                       result_t want);
        plan_row_t r;
        r       = '0;
        r.act   = act;
        r.idx   = idx;
        r.reps  = 1;
        r.typed = 1'b1;
        r.want  = want;
        plan.push_back(r);
    endfunction

    function automatic void plan_write(cfg_index_t sel, logic [CFG_DATA_W-1:0] value);
        plan_row_t r;
        r          = '0;
        r.is_write = 1'b1;
        r.sel      = sel;
        r.value    = value;
        plan.push_back(r);
    endfunction

    function automatic void check_field(string what, logic [DURATION_W-1:0] want,
                                        logic [DURATION_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
            faults++;
        end
    endfunction

    // Offers one item, waits for its transfer, records the expectation, and may pause.
    task automatic send(action_t act, logic [READ_INDEX_W-1:0] idx, bit typed,
                        result_t typed_status);
        result_t s;
        item_ch.valid      <= 1'b1;
        item_ch.action     <= act;
        item_ch.read_index <= idx;
        do
            @(posedge clk);
        while (!item_ch.ready);
        s = next_capture_status(act, idx);
        status_due.push_back(typed ? typed_status : s);
        sent++;
        if (!steady && gap_free == 0 && $urandom_range(0, 7) == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        if (gap_free != 0)
            gap_free--;
    endtask

    // Registers change only once every outstanding result has arrived.
    task automatic write_register(cfg_index_t sel, logic [CFG_DATA_W-1:0] value);
        item_ch.valid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (sel)
            REG_ENABLE: cap_enable = value[0];
            default:    idle_us    = value;
        endcase
    endtask

    // Result sink: random stalls, one long hold-off, and a stall-free tail.
    initial
    begin : status_sink
        int unsigned waited;
        forever
        begin
            if (hold_req && !held)
            begin
                status_ch.ready <= 1'b0;
                waited = 0;
                while (waited < HOLD_CYCLES)
                begin
                    @(posedge clk);
                    waited++;
                end
                held = 1'b1;
            end
            else if (!steady && $urandom_range(0, 7) == 0)
            begin
                status_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                status_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge clk)
    begin : status_check
        result_t want;
        if (rst_n && status_ch.valid === 1'b1 && status_ch.ready)
        begin
            if (status_due.size() == 0)
            begin
                $display("%0t: result transfer with nothing expected", $time);
                faults++;
            end
            else
            begin
                want = status_due.pop_front();
                received++;
                check_field("frame_ready", want.frame_ready, status_ch.frame_ready);
                check_field("frame_active", want.frame_active, status_ch.frame_active);
                check_field("frame_done", want.frame_done, status_ch.frame_done);
                check_field("stored_count", want.stored_count, status_ch.stored_count);
                check_field("read_duration", want.read_duration, status_ch.read_duration);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycles, status_due.size());
            $display("ir_edge_duration_capture_top: mismatch");
            $finish;
        end
    end

    initial
    begin : stimulus
        action_t                 act;
        logic [READ_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]   word;
        logic [CFG_DATA_W-1:0]   lim;
        bit                      en;
        int unsigned             tick_run;
        int unsigned             span;
        int unsigned             r;
        int unsigned             phase;
        int unsigned             n;

        rst_n              <= 1'b0;
        item_ch.valid      <= 1'b0;
        item_ch.action     <= ACT_TICK;
        item_ch.read_index <= '0;
        cfg_we             <= 1'b0;
        cfg_index          <= REG_ENABLE;
        cfg_data           <= '0;
        tick_run = 0;
        foreach (dur_mem[i])
            dur_mem[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset state, a short frame and out-of-range reads.
        plan_typed(ACT_READ, 8'd0, status(0, 0, 0, 0, 0));
        plan_typed(ACT_TICK, 8'd0, status(0, 0, 0, 0, 0));
        plan_typed(ACT_EDGE, 8'd0, status(0, 1, 0, 0, 0));
        plan_item(ACT_TICK, 8'd0, 20);
        plan_item(ACT_EDGE, 8'd0, 1);
        plan_item(ACT_READ, 8'd0, 1);
        plan_typed(ACT_READ, 8'd255, status(0, 1, 0, 1, 0));
        plan_typed(ACT_CLEAR, 8'hAA, status(0, 0, 0, 0, 0));
        // Zero idle limit: the first tick after a stored duration completes.
        // A held frame ignores edges and ticks.
        plan_write(REG_IDLE_LIMIT, 16'd0);
        plan_typed(ACT_EDGE, 8'd0, status(0, 1, 0, 0, 0));
        plan_typed(ACT_EDGE, 8'd0, status(0, 1, 0, 1, 0));
        plan_typed(ACT_TICK, 8'd0, status(1, 0, 1, 1, 0));
        plan_typed(ACT_EDGE, 8'd0, status(1, 0, 0, 1, 0));
        plan_typed(ACT_TICK, 8'd0, status(1, 0, 0, 1, 0));
        plan_typed(ACT_READ, 8'd0, status(1, 0, 0, 1, 0));
        plan_typed(ACT_CLEAR, 8'd0, status(0, 0, 0, 0, 0));
        // Edges are ignored while capture is disabled.
        plan_write(REG_ENABLE, 16'hFFFE);
        plan_typed(ACT_EDGE, 8'd0, status(0, 0, 0, 0, 0));
        // Idle limit of 65534, a full buffer, and completion with capture
        // disabled under a short idle limit.
        plan_write(REG_ENABLE, 16'h0001);
        plan_write(REG_IDLE_LIMIT, 16'd65534);
        plan_typed(ACT_EDGE, 8'd0, status(0, 1, 0, 0, 0));
        plan_item(ACT_TICK, 8'd0, 100);
        plan_item(ACT_EDGE, 8'd0, 1);
        plan_item(ACT_EDGE, 8'd0, 300);
        plan_item(ACT_READ, 8'd0, 1);
        plan_item(ACT_READ, 8'd255, 1);
        plan_write(REG_ENABLE, 16'h8000);
        plan_write(REG_IDLE_LIMIT, 16'd20);
        plan_item(ACT_TICK, 8'd0, 30);
        plan_typed(ACT_CLEAR, 8'd0, status(0, 0, 0, 0, 0));

        foreach (plan[k])
        begin
            if (plan[k].is_write)
                write_register(plan[k].sel, plan[k].value);
            else
                repeat (plan[k].reps)
                    send(plan[k].act, plan[k].idx, plan[k].typed, plan[k].want);
        end

        // Random frames under several register settings.
        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0:       begin en = 1'b1; lim = 16'd3; end
                1:       begin en = 1'b1; lim = 16'd0; end
                2:       begin en = ($urandom_range(0, 3) != 0);
                               lim = CFG_DATA_W'($urandom_range(1, 40)); end
                3:       begin en = 1'b1; lim = CFG_DATA_W'($urandom_range(5, 60)); end
                default: begin en = 1'b1; lim = 16'd1; end
            endcase
            word    = CFG_DATA_W'($urandom);
            word[0] = en;
            write_register(REG_ENABLE, word);
            write_register(REG_IDLE_LIMIT, lim);
            if (phase == 0)
            begin
                hold_req = 1'b1;
                gap_free = 300;
            end
            if (phase == PHASE_COUNT - 1)
                steady = 1'b1;

            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (tick_run != 0)
                begin
                    act = ACT_TICK;
                    tick_run--;
                end
                else
                begin
                    r = $urandom_range(0, 99);
                    if (frame_held)
                    begin
                        if (r < 55)      act = ACT_READ;
                        else if (r < 80) act = ACT_CLEAR;
                        else if (r < 90) act = ACT_EDGE;
                        else             act = ACT_TICK;
                    end
                    else if (in_frame)
                    begin
                        if (r < 35)
                            act = ACT_EDGE;
                        else if (r < 75)
                        begin
                            // A run of ticks; long ones complete the frame.
                            act      = ACT_TICK;
                            span     = (idle_us > 78) ? 80 : idle_us + 2;
                            tick_run = $urandom_range(0, span - 1);
                        end
                        else if (r < 92) act = ACT_READ;
                        else if (r < 96) act = ACT_CLEAR;
                        else             act = ACT_TICK;
                    end
                    else
                    begin
                        if (r < 65)      act = ACT_EDGE;
                        else if (r < 75) act = ACT_TICK;
                        else if (r < 93) act = ACT_READ;
                        else             act = ACT_CLEAR;
                    end
                end
                if (dur_count != 0 && $urandom_range(0, 1) == 1)
                    idx = READ_INDEX_W'($urandom_range(0, int'(dur_count) - 1));
                else
                    idx = READ_INDEX_W'($urandom_range(0, 255));
                send(act, idx, 1'b0, '0);
            end
        end

        // Let every outstanding result arrive.
        item_ch.valid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d transfers in, %0d results checked, %0d frames completed,",
                 sent, received, frames_done);
        $display("%0d reads of stored durations, and %0d cycles.", read_hits, cycles);
        if (faults == 0)
            $display("ir_edge_duration_capture_top: match");
        else
            $display("ir_edge_duration_capture_top: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
